// ===== rtl/z85_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_pkg: shared types and constants of the Z85 stream decoder
// Holds the character-to-digit table and the group record that the front
// end hands to the back end.
// ----------------------------------------------------------------------------
package z85_pkg;

  localparam int unsigned DigitW   = 7;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned TableLen = 96;
  localparam int unsigned GroupLen = 5;

  localparam logic [7:0]        CharOffset = 8'd32;
  localparam logic [31:0]       DigitBase  = 32'd85;
  localparam logic [2:0]        LastDigit  = 3'(GroupLen - 1);

  // One decoded group, or a size error when err is set.
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
    logic        err;
  } z85_group_t;

  typedef logic [DigitW-1:0] digit_t;

  localparam digit_t DigitOf [TableLen] = '{
    7'h00, 7'h44, 7'h00, 7'h54, 7'h53, 7'h52, 7'h48, 7'h00, 7'h4B, 7'h4C, 7'h46, 7'h41,
    7'h00, 7'h3F, 7'h3E, 7'h45, 7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
    7'h08, 7'h09, 7'h40, 7'h00, 7'h49, 7'h42, 7'h4A, 7'h47, 7'h51, 7'h24, 7'h25, 7'h26,
    7'h27, 7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h30, 7'h31, 7'h32,
    7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h4D,
    7'h00, 7'h4E, 7'h43, 7'h00, 7'h00, 7'h0A, 7'h0B, 7'h0C, 7'h0D, 7'h0E, 7'h0F, 7'h10,
    7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A, 7'h1B, 7'h1C,
    7'h1D, 7'h1E, 7'h1F, 7'h20, 7'h21, 7'h22, 7'h23, 7'h4F, 7'h00, 7'h50, 7'h00, 7'h00
  };

  // Map a raw character to its digit; indexes past the table give zero.
  function automatic digit_t lookup_digit(input logic [7:0] symbol);
    logic [7:0]        diff;
    logic [IndexW-1:0] idx;
    begin
      diff = symbol - CharOffset;
      idx  = diff[IndexW-1:0];
      if (int'(idx) >= TableLen) begin
        lookup_digit = '0;
      end else begin
        lookup_digit = DigitOf[idx];
      end
    end
  endfunction

endpackage

// ===== rtl/z85_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_front: character intake and group accumulation
// Folds each digit into the accumulator and hands a finished group or a
// size error to the group queue.
// ----------------------------------------------------------------------------
module z85_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           symbol,
  input  logic                 is_final,
  input  logic                 q_full,
  output logic                 q_push,
  output z85_pkg::z85_group_t  q_data
);

  logic [31:0]            acc;
  logic [31:0]            acc_next;
  logic [2:0]             count;
  logic                   accept;
  logic                   group_done;
  z85_pkg::digit_t        digit;

  assign full       = q_full;
  assign accept     = push && !q_full;
  assign digit      = z85_pkg::lookup_digit(symbol);
  assign acc_next   = 32'(acc * z85_pkg::DigitBase) + 32'(digit);
  assign group_done = (count == z85_pkg::LastDigit);

  always_comb begin
    q_push = accept && (group_done || is_final);
    if (group_done) begin
      q_data.word = acc_next;
      q_data.fin  = is_final;
      q_data.err  = 1'b0;
    end else begin
      q_data.word = '0;
      q_data.fin  = 1'b1;
      q_data.err  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (accept) begin
      if (group_done || is_final) begin
        acc   <= '0;
        count <= '0;
      end else begin
        acc   <= acc_next;
        count <= count + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/z85_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_queue: short group queue between front and back
// First-in first-out store of group records held in flops.
// ----------------------------------------------------------------------------
module z85_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  z85_pkg::z85_group_t  wdata,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output z85_pkg::z85_group_t  rdata
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  z85_pkg::z85_group_t  slots [DEPTH];
  logic [PtrW-1:0]      wptr;
  logic [PtrW-1:0]      rptr;
  logic [CntW-1:0]      fill;

  assign full  = (fill == CntW'(DEPTH));
  assign valid = (fill != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/z85_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_back: result serializer
// Holds one group record and presents its bytes, most significant first,
// one result beat at a time.
// ----------------------------------------------------------------------------
module z85_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  z85_pkg::z85_group_t  q_data,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 stream_end,
  output logic                 size_error
);

  z85_pkg::z85_group_t  cur;
  logic                 busy;
  logic [1:0]           sel;
  logic                 last_beat;
  logic                 take;

  assign last_beat = cur.err || (sel == 2'd3);
  assign take      = !busy || (pop && last_beat);
  assign q_pop     = take && q_valid;

  assign empty      = !busy;
  assign run_last   = last_beat;
  assign stream_end = last_beat && cur.fin;
  assign size_error = cur.err;

  always_comb begin
    case (sel)
      2'd0:    out_byte = cur.word[31:24];
      2'd1:    out_byte = cur.word[23:16];
      2'd2:    out_byte = cur.word[15:8];
      default: out_byte = cur.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= '0;
    end else if (take) begin
      busy <= q_valid;
      sel  <= '0;
    end else if (pop) begin
      sel  <= sel + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
  end

endmodule

// ===== rtl/z85_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_stream_decoder: streaming Z85 text decoder
// Turns a stream of Z85 characters into decoded bytes, four per group of
// five characters, and flags strings whose length is not a multiple of five.
// ----------------------------------------------------------------------------
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------------
//  input    | push / full    | symbol[7:0], is_final
//  result   | empty / pop    | out_byte[7:0], run_last, stream_end, size_error
//
// Cycles: one character is taken per cycle while the group queue has room;
// the front end folds the digit (one 32x7 multiply-add) in that same cycle.
// The back end delivers one result beat per cycle while pop is held high, so
// four bytes per five characters keep up at full input rate. The first result
// of a group is written into the group queue and then into the back end's
// record holder before it shows on the result ports.
// Reset: rst clears the accumulator, digit count and queue, and marks the result holder empty.
// Stalls: full rises only when the group queue is full; results wait in the
// back end while characters keep flowing.
// ----------------------------------------------------------------------------
module z85_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  symbol,
  input  logic        is_final,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end,
  output logic        size_error
);

  // group queue handshake
  logic                 gq_push;
  logic                 gq_full;
  logic                 gq_pop;
  logic                 gq_valid;
  z85_pkg::z85_group_t  gq_wdata;
  z85_pkg::z85_group_t  gq_rdata;

  // front: accumulate digits, push a record per finished group or error
  z85_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .symbol   (symbol),
    .is_final (is_final),
    .q_full   (gq_full),
    .q_push   (gq_push),
    .q_data   (gq_wdata)
  );

  // hold finished groups so front and back stall independently
  z85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (gq_push),
    .wdata (gq_wdata),
    .full  (gq_full),
    .pop   (gq_pop),
    .valid (gq_valid),
    .rdata (gq_rdata)
  );

  // back: split each record into result beats
  z85_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (gq_valid),
    .q_data     (gq_rdata),
    .q_pop      (gq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end),
    .size_error (size_error)
  );

endmodule

// ===== tb/sv/z85_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_decode_checker: scoreboard for the Z85 stream decoder
// Watches the character and byte channels, folds every accepted character
// into its own accumulator, queues the bytes it predicts and compares each
// delivered beat against the oldest one.
// ----------------------------------------------------------------------------
module z85_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] symbol,
  input  logic       is_final,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       stream_end,
  input  logic       size_error,
  output int         fail_count,
  output int         beats_due
);

  localparam logic [31:0] RADIX      = 32'd85;
  localparam logic [7:0]  SPACE_CHAR = 8'd32;
  localparam logic [6:0]  TABLE_END  = 7'd96;
  localparam logic [2:0]  FIFTH_SLOT = 3'd4;

  localparam logic [6:0] DIGIT_TABLE [96] = '{
    7'h00, 7'h44, 7'h00, 7'h54, 7'h53, 7'h52, 7'h48, 7'h00, 7'h4B, 7'h4C, 7'h46, 7'h41,
    7'h00, 7'h3F, 7'h3E, 7'h45, 7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
    7'h08, 7'h09, 7'h40, 7'h00, 7'h49, 7'h42, 7'h4A, 7'h47, 7'h51, 7'h24, 7'h25, 7'h26,
    7'h27, 7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h30, 7'h31, 7'h32,
    7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h4D,
    7'h00, 7'h4E, 7'h43, 7'h00, 7'h00, 7'h0A, 7'h0B, 7'h0C, 7'h0D, 7'h0E, 7'h0F, 7'h10,
    7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A, 7'h1B, 7'h1C,
    7'h1D, 7'h1E, 7'h1F, 7'h20, 7'h21, 7'h22, 7'h23, 7'h4F, 7'h00, 7'h50, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       fin;
    logic       err;
  } byte_beat_t;

  logic [31:0] acc_word;
  logic [2:0]  digits_held;
  byte_beat_t  due_bytes [$];

  initial begin
    fail_count  = 0;
    beats_due   = 0;
    acc_word    = '0;
    digits_held = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Fold one character; queue four bytes on a full group, one error beat on
  // a final character that leaves a partial group.
  function automatic void fold_symbol(input logic [7:0] sym, input logic fin);
    logic [7:0]  diff;
    logic [6:0]  idx;
    logic [6:0]  digit;
    logic [31:0] word;
    byte_beat_t  b;
    begin
      diff  = sym - SPACE_CHAR;
      idx   = diff[6:0];
      digit = (idx >= TABLE_END) ? 7'd0 : DIGIT_TABLE[idx];
      word  = acc_word * RADIX + {25'd0, digit};
      if (digits_held == FIFTH_SLOT) begin
        for (int k = 0; k < 4; k++) begin
          b.value = word[31 - 8 * k -: 8];
          b.last  = (k == 3);
          b.fin   = (k == 3) && fin;
          b.err   = 1'b0;
          due_bytes.push_back(b);
        end
        acc_word    = '0;
        digits_held = '0;
      end else if (fin) begin
        b = '{value: 8'd0, last: 1'b1, fin: 1'b1, err: 1'b1};
        due_bytes.push_back(b);
        acc_word    = '0;
        digits_held = '0;
      end else begin
        acc_word    = word;
        digits_held = digits_held + 3'd1;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    byte_beat_t want;
    if (rst) begin
      acc_word    = '0;
      digits_held = '0;
    end else begin
      // retire the delivered beat first; it can only stem from older characters
      if (pop && !empty) begin
        if (due_bytes.size() == 0) begin
          report_mismatch("unexpected beat, out_byte", out_byte, 0);
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.value) report_mismatch("out_byte", out_byte, want.value);
          if (run_last !== want.last) report_mismatch("run_last", run_last, want.last);
          if (stream_end !== want.fin) report_mismatch("stream_end", stream_end, want.fin);
          if (size_error !== want.err) report_mismatch("size_error", size_error, want.err);
        end
      end
      if (push && !full) begin
        fold_symbol(symbol, is_final);
      end
    end
    beats_due <= due_bytes.size();
  end

endmodule

// ===== tb/sv/tb_z85_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_z85_stream_decoder: testbench top for the Z85 stream decoder
// Drives a directed set of strings, then random well-formed and broken
// strings with random idling on both channels; the checker scores every byte.
// ----------------------------------------------------------------------------
module tb_z85_stream_decoder;

  localparam int RANDOM_ITEMS = 206;
  localparam int QUIET_FROM   = 170;   // no idling after this many random chars
  localparam int HOLD_CYCLES  = 100;   // long receiver hold-off
  localparam int DRAIN_WAIT   = 10;    // idle time after the predicted bytes drain
  localparam int STALL_LIMIT  = 3000;  // cycles with no beat on either side

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       push       = 1'b0;
  logic [7:0] symbol     = 8'd0;
  logic       is_final   = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;
  logic       size_error;

  int fail_count;
  int beats_due;
  int stall_cycles = 0;
  int random_sent  = 0;
  bit quiet        = 1'b0;   // suppress idling on both channels
  bit no_gaps      = 1'b0;   // sender only: back-to-back characters
  bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off

  always #4 clk = ~clk;

  z85_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .symbol    (symbol),
    .is_final  (is_final),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .stream_end(stream_end),
    .size_error(size_error)
  );

  z85_decode_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .symbol    (symbol),
    .is_final  (is_final),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .stream_end(stream_end),
    .size_error(size_error),
    .fail_count(fail_count),
    .beats_due (beats_due)
  );

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("z85_stream_decoder test failed");
        $finish;
      end
    end
  end

  // Receiver: pop most cycles, drop it for random bursts, and honor one long
  // hold-off so the decoder's group queue fills and full rises.
  initial begin : result_side
    int burst;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one character and hold it until the edge that accepts it. Called
  // at a rising edge; returns at the accepting edge with push still high.
  task automatic send_char(input logic [7:0] sym, input logic fin);
    int burst;
    if (!quiet && !no_gaps && $urandom_range(0, 5) == 0) begin
      // idle the sender for a burst before this beat
      burst = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    push     <= 1'b1;
    symbol   <= sym;
    is_final <= fin;
    do @(posedge clk); while (full);
  endtask

  // Send a text literal, marking its last character final when asked.
  task automatic send_text(input string txt, input bit fin_at_end);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i], fin_at_end && (i == txt.len() - 1));
    end
  endtask

  // Send one random string: well-formed groups of mostly printable characters,
  // a broken length, or a run of noise bytes with no final flag.
  task automatic send_random_string(input int kind);
    int len;
    bit fin_at_end;
    bit printable;
    logic [7:0] sym;
    begin
      if (kind <= 6) begin
        len        = 5 * $urandom_range(1, 3);
        fin_at_end = 1'b1;
        printable  = ($urandom_range(0, 7) != 0);
      end else if (kind <= 8) begin
        len        = $urandom_range(1, 12);
        fin_at_end = 1'b1;
        printable  = 1'($urandom_range(0, 1));
      end else begin
        len        = $urandom_range(1, 6);
        fin_at_end = 1'b0;
        printable  = 1'b0;
      end
      for (int i = 0; i < len; i++) begin
        sym = printable ? 8'($urandom_range(33, 125)) : 8'($urandom_range(0, 255));
        send_char(sym, fin_at_end && (i == len - 1));
        random_sent++;
        if (random_sent >= QUIET_FROM) quiet = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    bit held_once;
    bit drained_once;
    held_once    = 1'b0;
    drained_once = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // largest digits: the group value wraps past 2^32, final on the fifth
    send_text("#####", 1'b1);
    // two full groups of a known string, final on the last
    send_text("HelloWorld", 1'b1);
    // final on the first character of a string: size error
    send_text("x", 1'b1);
    // final inside a partial group: size error
    send_text("abc", 1'b1);
    // extreme raw bytes: below the table, past the table, top of range
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h9F, 1'b1);

    // Random part.
    while (random_sent < RANDOM_ITEMS) begin
      if (!held_once && random_sent >= 60) begin
        // hold the receiver off and keep offering back to back
        held_once    = 1'b1;
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        for (int g = 0; g < 8; g++) send_random_string(0);
        no_gaps      = 1'b0;
      end else if (!drained_once && random_sent >= 120) begin
        // pause the sender until every predicted byte has come out
        drained_once = 1'b1;
        push <= 1'b0;
        @(posedge clk);
        wait (beats_due == 0);
        @(posedge clk);
      end else begin
        send_random_string($urandom_range(0, 9));
      end
    end

    push <= 1'b0;
    @(posedge clk);
    wait (beats_due == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && beats_due == 0) begin
      $display("z85_stream_decoder test passed");
    end else begin
      $display("z85_stream_decoder test failed");
    end
    $finish;
  end

endmodule
